[rtl/isotropic_direction_sampler_core_defines.svh]
// Assertion macros for the sampler RTL.
`ifndef ISOTROPIC_DIRECTION_SAMPLER_CORE_DEFINES_SVH
`define ISOTROPIC_DIRECTION_SAMPLER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IDSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IDSC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IDSC_ASSERT(label, prop, msg)
`define IDSC_ASSERT_RST(label, prop, msg)
`endif
`endif

[rtl/idsc_pkg.sv]
// ----------------------------------------------------------------------------
// Direction sampler package
// Shared types, register indexes and CORDIC constants.
// ----------------------------------------------------------------------------
package idsc_pkg;

    localparam int SQRT_STEPS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam logic [29:0] KQ30 = 30'd652032874;

    localparam logic [1:0] REG_LOC_X = 2'd0;
    localparam logic [1:0] REG_LOC_Y = 2'd1;
    localparam logic [1:0] REG_LOC_Z = 2'd2;

    typedef struct packed {
        logic               vld;
        logic [31:0]        n;
        logic [31:0]        res;
        logic signed [16:0] zq;
        logic [1:0]         quad;
        logic signed [24:0] ang;
        logic signed [32:0] x;
        logic signed [32:0] y;
    } t_stage;

    // Arctangent of 2^-i in units of 2^-24 turn, rounded to nearest.
    function automatic logic signed [24:0] atan_tab(input int step);
        logic signed [24:0] v;
        case (step)
            0:  v = 25'sd2097152;
            1:  v = 25'sd1238021;
            2:  v = 25'sd654136;
            3:  v = 25'sd332050;
            4:  v = 25'sd166669;
            5:  v = 25'sd83416;
            6:  v = 25'sd41718;
            7:  v = 25'sd20860;
            8:  v = 25'sd10430;
            9:  v = 25'sd5215;
            10: v = 25'sd2608;
            11: v = 25'sd1304;
            12: v = 25'sd652;
            13: v = 25'sd326;
            14: v = 25'sd163;
            default: v = 25'sd81;
        endcase
        return v;
    endfunction

endpackage

[rtl/idsc_in_if.sv]
// ----------------------------------------------------------------------------
// Sampler input channel
// Valid/ready channel carrying one pair of uniform fractions.
// ----------------------------------------------------------------------------
interface idsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] u_polar;
    logic [15:0] u_azimuth;

    modport source (output valid, output u_polar, output u_azimuth, input ready);
    modport sink   (input valid, input u_polar, input u_azimuth, output ready);
endinterface

[rtl/idsc_out_if.sv]
// ----------------------------------------------------------------------------
// Sampler output channel
// Valid/ready channel carrying one direction and ray origin.
// ----------------------------------------------------------------------------
interface idsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                    input pos_x, input pos_y, input pos_z, output ready);
endinterface

[rtl/idsc_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root, registered.
// ----------------------------------------------------------------------------
module idsc_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  idsc_pkg::t_stage i_st,
    output idsc_pkg::t_stage o_st
);
    localparam logic [31:0] BIT = 32'(1) << (30 - 2 * STEP);

    idsc_pkg::t_stage r_st;
    idsc_pkg::t_stage n_st;
    logic [31:0]      w_trial;

    always_comb begin
        n_st    = i_st;
        w_trial = i_st.res + BIT;
        if (i_st.n >= w_trial) begin
            n_st.n   = i_st.n - w_trial;
            n_st.res = (i_st.res >> 1) + BIT;
        end else begin
            n_st.res = i_st.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule

[rtl/idsc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation of the vector toward the residual angle, registered.
// ----------------------------------------------------------------------------
module idsc_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  idsc_pkg::t_stage i_st,
    output idsc_pkg::t_stage o_st
);
    localparam logic signed [24:0] ATAN = idsc_pkg::atan_tab(STEP);

    idsc_pkg::t_stage   r_st;
    idsc_pkg::t_stage   n_st;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;

    always_comb begin
        n_st = i_st;
        w_dx = i_st.y >>> STEP;
        w_dy = i_st.x >>> STEP;
        if (!i_st.ang[24]) begin
            n_st.x   = i_st.x - w_dx;
            n_st.y   = i_st.y + w_dy;
            n_st.ang = i_st.ang - ATAN;
        end else begin
            n_st.x   = i_st.x + w_dx;
            n_st.y   = i_st.y - w_dy;
            n_st.ang = i_st.ang + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule

[rtl/isotropic_direction_sampler_core.sv]
// ----------------------------------------------------------------------------
// Isotropic direction sampler
// Maps two uniform fractions to a unit direction uniform on the sphere.
// ----------------------------------------------------------------------------
// Usage: i_in takes one transaction of (u_polar, u_azimuth); o_out returns
// one transaction with the direction in Q1.15 and the configured source
// location in Q16.16. Location registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_wdata; the user writes them only while idle, the block does not enforce it.
// The chain has 35 register stages: one squaring stage, sixteen square root
// cells, one scaling multiplier, sixteen CORDIC cells and the output register.
// o_out.valid rises when an accepted transaction has passed these stages in
// order and reaches the output register. Throughput is one transaction per
// cycle while no result is stalled; the chain of cells advances as one pipeline.
// When the receiver stalls with a result waiting, the whole chain holds and
// i_in.ready drops until the result is taken.
// Synchronous reset clears all valid flags and the location registers.
// ----------------------------------------------------------------------------
`include "isotropic_direction_sampler_core_defines.svh"

module isotropic_direction_sampler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idsc_in_if.sink     i_in,
    idsc_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    localparam int NS = idsc_pkg::SQRT_STEPS;
    localparam int NC = idsc_pkg::CORDIC_STEPS;

    logic [31:0] r_loc_x, r_loc_y, r_loc_z;
    logic        w_en;

    idsc_pkg::t_stage w_st [0:NS+NC+1];
    idsc_pkg::t_stage r_sq, n_sq;
    idsc_pkg::t_stage r_mul, n_mul;

    logic signed [16:0] w_zq;
    logic [15:0]        w_abs;
    logic [46:0]        w_prod;

    logic               r_out_vld;
    logic signed [15:0] r_dx, r_dy, r_dz;
    logic signed [15:0] n_dx, n_dy, n_dz;
    logic signed [32:0] w_ox, w_oy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc_x <= '0;
            r_loc_y <= '0;
            r_loc_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                idsc_pkg::REG_LOC_X: r_loc_x <= i_cfg_wdata;
                idsc_pkg::REG_LOC_Y: r_loc_y <= i_cfg_wdata;
                idsc_pkg::REG_LOC_Z: r_loc_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // Squaring stage: n = 2^30 - zq^2.
    always_comb begin
        w_zq       = 17'sd32768 - $signed({1'b0, i_in.u_polar});
        w_abs      = w_zq[16] ? 16'(-w_zq) : w_zq[15:0];
        n_sq       = '0;
        n_sq.vld   = i_in.valid;
        n_sq.n     = 32'(1) << 30;
        n_sq.n     = n_sq.n - 32'(w_abs) * 32'(w_abs);
        n_sq.res   = '0;
        n_sq.zq    = w_zq;
        n_sq.quad  = i_in.u_azimuth[15:14];
        n_sq.ang   = $signed({3'b000, i_in.u_azimuth[13:0], 8'h00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.vld <= 1'b0;
        end else if (w_en) begin
            r_sq <= n_sq;
        end
    end

    assign w_st[0] = r_sq;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        idsc_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_st   (w_st[g]),
            .o_st   (w_st[g+1])
        );
    end

    // Gain-compensated start vector for the rotation.
    always_comb begin
        w_prod  = 47'(w_st[NS].res[16:0]) * 47'(idsc_pkg::KQ30);
        n_mul   = w_st[NS];
        n_mul.x = $signed({1'b0, w_prod[46:15]});
        n_mul.y = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.vld <= 1'b0;
        end else if (w_en) begin
            r_mul <= n_mul;
        end
    end

    assign w_st[NS+1] = r_mul;

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        idsc_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_st   (w_st[NS+1+g]),
            .o_st   (w_st[NS+2+g])
        );
    end

    function automatic logic signed [15:0] round_sat(input logic signed [32:0] v);
        logic signed [33:0] s;
        logic signed [18:0] q;
        s = 34'(v) + 34'sd16384;
        q = 19'(s >>> 15);
        if (q > 19'sd32767) begin
            return 16'sd32767;
        end else if (q < -19'sd32768) begin
            return -16'sd32768;
        end
        return q[15:0];
    endfunction

    // Quadrant mapping, rounding and saturation.
    always_comb begin
        case (w_st[NS+NC+1].quad)
            2'd0: begin
                w_ox = w_st[NS+NC+1].x;
                w_oy = w_st[NS+NC+1].y;
            end
            2'd1: begin
                w_ox = -w_st[NS+NC+1].y;
                w_oy = w_st[NS+NC+1].x;
            end
            2'd2: begin
                w_ox = -w_st[NS+NC+1].x;
                w_oy = -w_st[NS+NC+1].y;
            end
            default: begin
                w_ox = w_st[NS+NC+1].y;
                w_oy = -w_st[NS+NC+1].x;
            end
        endcase
        n_dx = round_sat(w_ox);
        n_dy = round_sat(w_oy);
        n_dz = (w_st[NS+NC+1].zq > 17'sd32767) ? 16'sd32767 : w_st[NS+NC+1].zq[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_st[NS+NC+1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_dz <= n_dz;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.dir_x = r_dx;
    assign o_out.dir_y = r_dy;
    assign o_out.dir_z = r_dz;
    assign o_out.pos_x = r_loc_x;
    assign o_out.pos_y = r_loc_y;
    assign o_out.pos_z = r_loc_z;

    `IDSC_ASSERT(a_stall_blocks_input, (o_out.valid && !o_out.ready) |-> !i_in.ready, "input accepted during output stall")
    `IDSC_ASSERT(a_dirz_range, o_out.valid |-> (o_out.dir_z != -16'sd32768), "dir_z out of range")
    `IDSC_ASSERT(a_sqrt_range, w_st[NS].vld |-> (w_st[NS].res <= 32'd32768), "square root above one")
    `IDSC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_out.valid, "output valid after reset")
endmodule

[tb/tb_isotropic_direction_sampler_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direction sampler testbench
// Sends pairs of uniform fractions through the sampler with random gaps and
// receiver stalls. Each direction and ray origin is compared with a local
// fixed-point predictor (square root plus rotation CORDIC) that tracks the
// location registers written between phases.
// ----------------------------------------------------------------------------
module tb_isotropic_direction_sampler_core;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 45;

    typedef struct {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_ray;

    localparam longint ATAN_TURN [16] = '{2097152, 1238021, 654136, 332050, 166669,
        83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    idsc_in_if  in_ch ();
    idsc_out_if out_ch ();

    isotropic_direction_sampler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] src_loc [3];
    t_ray        pending_rays [$];
    int          error_count = 0;
    int          stall_left = 0;
    bit          steady_mode = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint round_q15(input longint q30);
        longint v;
        v = (q30 + 16384) >>> 15;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic t_ray predict_ray(input logic [15:0] polar, input logic [15:0] azim);
        t_ray   r;
        longint zq, n, res, bitv, x, y, ang, dx, dy, ox, oy;
        zq = 32768 - longint'(polar);
        n = (64'sd1 << 30) - zq * zq;
        res = 0;
        bitv = 64'sd1 << 30;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        x = (res * longint'(idsc_pkg::KQ30)) >>> 15;
        y = 0;
        ang = longint'(azim[13:0]) << 8;
        for (int i = 0; i < idsc_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x = x - dx; y = y + dy; ang = ang - ATAN_TURN[i];
            end else begin
                x = x + dx; y = y - dy; ang = ang + ATAN_TURN[i];
            end
        end
        case (azim[15:14])
            2'd0: begin ox = x;  oy = y;  end
            2'd1: begin ox = -y; oy = x;  end
            2'd2: begin ox = -x; oy = -y; end
            default: begin ox = y; oy = -x; end
        endcase
        r.dir_x = 16'(round_q15(ox));
        r.dir_y = 16'(round_q15(oy));
        r.dir_z = (zq > 32767) ? 16'sd32767 : 16'(zq);
        r.pos_x = src_loc[idsc_pkg::REG_LOC_X];
        r.pos_y = src_loc[idsc_pkg::REG_LOC_Y];
        r.pos_z = src_loc[idsc_pkg::REG_LOC_Z];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Valid stays high between back-to-back transactions; it only drops for a gap.
    task automatic send_fractions(input logic [15:0] polar, input logic [15:0] azim);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.u_polar   <= polar;
        in_ch.u_azimuth <= azim;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_rays.insert(pending_rays.size(), predict_ray(polar, azim));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_location(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (idx != REG_UNUSED) src_loc[idx] = value;
    endtask

    task automatic set_location(input logic [31:0] lx, input logic [31:0] ly,
                                input logic [31:0] lz);
        write_location(idsc_pkg::REG_LOC_X, lx);
        write_location(idsc_pkg::REG_LOC_Y, ly);
        write_location(idsc_pkg::REG_LOC_Z, lz);
        write_location(REG_UNUSED, $urandom());
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stalls, and the comparison of every accepted transaction.
    always @(posedge i_clk) begin
        t_ray want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_rays.size() == 0) begin
                    report_mismatch("result with no expectation waiting");
                end else begin
                    want = pending_rays.pop_front();
                    if (out_ch.dir_x !== want.dir_x)
                        report_mismatch($sformatf("dir_x %0d exp %0d", out_ch.dir_x, want.dir_x));
                    if (out_ch.dir_y !== want.dir_y)
                        report_mismatch($sformatf("dir_y %0d exp %0d", out_ch.dir_y, want.dir_y));
                    if (out_ch.dir_z !== want.dir_z)
                        report_mismatch($sformatf("dir_z %0d exp %0d", out_ch.dir_z, want.dir_z));
                    if (out_ch.pos_x !== want.pos_x)
                        report_mismatch($sformatf("pos_x %h exp %h", out_ch.pos_x, want.pos_x));
                    if (out_ch.pos_y !== want.pos_y)
                        report_mismatch($sformatf("pos_y %h exp %h", out_ch.pos_y, want.pos_y));
                    if (out_ch.pos_z !== want.pos_z)
                        report_mismatch($sformatf("pos_z %h exp %h", out_ch.pos_z, want.pos_z));
                end
            end
            // Mostly short stalls, with an occasional long one.
            if (steady_mode) begin
                out_ch.ready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    task automatic test_directed();
        logic [15:0] polar_pts [6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                                       16'hFFFE, 16'hFFFF};
        logic [15:0] azim_pts [8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                                      16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
        set_location(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send_fractions(polar_pts[i], azim_pts[i]);
        for (int i = 0; i < 8; i++) send_fractions(16'h4000, azim_pts[i]);
        send_fractions(16'hFFFF, 16'hFFFF);
        send_fractions(16'hAAAA, 16'h5555);
        send_fractions(16'h5555, 16'hAAAA);
        drain_results();
    endtask

    task automatic test_random_phase(input int count, input bit steady);
        set_location($urandom(), $urandom(), $urandom());
        steady_mode = steady;
        for (int i = 0; i < count; i++) begin
            send_fractions(16'($urandom()), 16'($urandom()));
            // Hold off once so the pipeline runs completely empty mid-phase.
            if (i == count / 2) begin
                in_ch.valid <= 1'b0;
                while (pending_rays.size() != 0) @(posedge i_clk);
            end
        end
        drain_results();
        steady_mode = 1'b0;
    endtask

    task automatic test_location_extremes();
        set_location(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        for (int i = 0; i < 20; i++) send_fractions(16'($urandom()), 16'($urandom()));
        drain_results();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= idsc_pkg::REG_LOC_X;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.u_polar   <= '0;
        in_ch.u_azimuth <= '0;
        for (int i = 0; i < 3; i++) src_loc[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_location_extremes();
        test_random_phase(500, 1'b0);
        test_random_phase(300, 1'b1);
        test_random_phase(500, 1'b0);
        test_random_phase(500, 1'b0);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
